@@ rtl/core/nmea_pkg.sv @@
// ----------------------------------------------------------------------------
// nmea_pkg
// Shared types and constants for the NMEA sentence checker.
// ----------------------------------------------------------------------------
package nmea_pkg;

  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] LIMIT_RESET = 8'd75;

  localparam logic [23:0] CHARS_GGA = 24'h474741;
  localparam logic [23:0] CHARS_GLL = 24'h474C4C;
  localparam logic [23:0] CHARS_VTG = 24'h565447;

  localparam logic [7:0] KIND_POS_FIRST  = 8'd3;
  localparam logic [7:0] KIND_POS_SECOND = 8'd4;
  localparam logic [7:0] KIND_POS_THIRD  = 8'd5;

  typedef enum logic [5:0] {
    PH_FIRST = 6'b000001,
    PH_SUM   = 6'b000010,
    PH_HEX1  = 6'b000100,
    PH_HEX2  = 6'b001000,
    PH_DONE  = 6'b010000,
    PH_FAULT = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    FAULT_OK        = 3'd0,
    FAULT_NO_DOLLAR = 3'd1,
    FAULT_LENGTH    = 3'd2,
    FAULT_NO_STAR   = 3'd3,
    FAULT_CHECKSUM  = 3'd4
  } fault_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_GGA   = 2'd1,
    KIND_GLL   = 2'd2,
    KIND_VTG   = 2'd3
  } kind_t;

  typedef struct packed {
    logic       ok;
    fault_t     fault;
    logic [7:0] sum;
    kind_t      kind;
  } result_t;

  // uppercase ASCII hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] d;
    if (n < 4'd10) begin
      d = {4'h3, n};
    end else begin
      d = 8'h37 + {4'h0, n};
    end
    return d;
  endfunction

endpackage

@@ rtl/core/nmea_tracker.sv @@
// ----------------------------------------------------------------------------
// nmea_tracker
// Per-sentence state: phase, running XOR, position, type characters and
// received checksum digits. Produces the result for a terminating return.
// ----------------------------------------------------------------------------
module nmea_tracker (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          length_limit,
  output logic                skip_next,
  output logic                fire,
  output nmea_pkg::result_t   result
);

  nmea_pkg::phase_t phase, phase_next;
  nmea_pkg::fault_t fault_latched, fault_latched_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [7:0]  char_position, char_position_next;
  logic [23:0] kind_chars, kind_chars_next;
  logic [7:0]  hex_first, hex_first_next;
  logic [7:0]  hex_second, hex_second_next;
  logic        skip_next_next;

  nmea_pkg::fault_t final_fault;
  nmea_pkg::kind_t  kind_code;
  logic             is_cr;

  assign is_cr = (rx_byte == nmea_pkg::CH_CR);
  assign fire  = take && !skip_next && is_cr;

  always_comb begin
    case (phase)
      nmea_pkg::PH_FIRST: final_fault = nmea_pkg::FAULT_NO_DOLLAR;
      nmea_pkg::PH_SUM: begin
        if (({1'b0, char_position} + 9'd1) >= {1'b0, length_limit}) begin
          final_fault = nmea_pkg::FAULT_LENGTH;
        end else begin
          final_fault = nmea_pkg::FAULT_NO_STAR;
        end
      end
      nmea_pkg::PH_HEX1, nmea_pkg::PH_HEX2, nmea_pkg::PH_DONE: begin
        if (hex_first == nmea_pkg::hex_digit(running_xor[7:4]) &&
            hex_second == nmea_pkg::hex_digit(running_xor[3:0])) begin
          final_fault = nmea_pkg::FAULT_OK;
        end else begin
          final_fault = nmea_pkg::FAULT_CHECKSUM;
        end
      end
      default: final_fault = fault_latched;
    endcase
  end

  always_comb begin
    case (kind_chars)
      nmea_pkg::CHARS_GGA: kind_code = nmea_pkg::KIND_GGA;
      nmea_pkg::CHARS_GLL: kind_code = nmea_pkg::KIND_GLL;
      nmea_pkg::CHARS_VTG: kind_code = nmea_pkg::KIND_VTG;
      default:             kind_code = nmea_pkg::KIND_OTHER;
    endcase
  end

  assign result.ok    = (final_fault == nmea_pkg::FAULT_OK);
  assign result.fault = final_fault;
  assign result.sum   = (phase == nmea_pkg::PH_FIRST) ? 8'h00 : running_xor;
  assign result.kind  = kind_code;

  always_comb begin
    phase_next         = phase;
    fault_latched_next = fault_latched;
    running_xor_next   = running_xor;
    char_position_next = char_position;
    kind_chars_next    = kind_chars;
    hex_first_next     = hex_first;
    hex_second_next    = hex_second;
    skip_next_next     = skip_next;
    if (take) begin
      if (skip_next) begin
        skip_next_next = 1'b0;
      end else if (is_cr) begin
        phase_next         = nmea_pkg::PH_FIRST;
        fault_latched_next = nmea_pkg::FAULT_OK;
        running_xor_next   = 8'h00;
        char_position_next = 8'h00;
        kind_chars_next    = 24'h000000;
        hex_first_next     = 8'h00;
        hex_second_next    = 8'h00;
        skip_next_next     = 1'b1;
      end else begin
        case (char_position)
          nmea_pkg::KIND_POS_FIRST:  kind_chars_next[23:16] = rx_byte;
          nmea_pkg::KIND_POS_SECOND: kind_chars_next[15:8]  = rx_byte;
          nmea_pkg::KIND_POS_THIRD:  kind_chars_next[7:0]   = rx_byte;
          default: ;
        endcase
        case (phase)
          nmea_pkg::PH_FIRST: begin
            if (rx_byte == nmea_pkg::CH_DOLLAR) begin
              phase_next = nmea_pkg::PH_SUM;
            end else begin
              fault_latched_next = nmea_pkg::FAULT_NO_DOLLAR;
              phase_next         = nmea_pkg::PH_FAULT;
            end
          end
          nmea_pkg::PH_SUM: begin
            if (char_position >= length_limit || rx_byte == nmea_pkg::CH_NUL) begin
              fault_latched_next = nmea_pkg::FAULT_LENGTH;
              phase_next         = nmea_pkg::PH_FAULT;
            end else if (rx_byte == nmea_pkg::CH_STAR) begin
              phase_next = nmea_pkg::PH_HEX1;
            end else begin
              running_xor_next = running_xor ^ rx_byte;
            end
          end
          nmea_pkg::PH_HEX1: begin
            hex_first_next = rx_byte;
            phase_next     = nmea_pkg::PH_HEX2;
          end
          nmea_pkg::PH_HEX2: begin
            hex_second_next = rx_byte;
            phase_next      = nmea_pkg::PH_DONE;
          end
          default: ;
        endcase
        if (char_position != 8'hFF) begin
          char_position_next = char_position + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= nmea_pkg::PH_FIRST;
      fault_latched <= nmea_pkg::FAULT_OK;
      running_xor   <= 8'h00;
      char_position <= 8'h00;
      kind_chars    <= 24'h000000;
      hex_first     <= 8'h00;
      hex_second    <= 8'h00;
      skip_next     <= 1'b0;
    end else begin
      phase         <= phase_next;
      fault_latched <= fault_latched_next;
      running_xor   <= running_xor_next;
      char_position <= char_position_next;
      kind_chars    <= kind_chars_next;
      hex_first     <= hex_first_next;
      hex_second    <= hex_second_next;
      skip_next     <= skip_next_next;
    end
  end

endmodule

@@ rtl/core/nmea_sentence_checker.sv @@
// ----------------------------------------------------------------------------
// nmea_sentence_checker
// Checks NMEA 0183 sentences byte by byte and reports one result per sentence.
//
// Channels: the byte stream enters on in_valid/in_ready with rx_byte; results
// leave on out_valid/out_ready with sentence_ok, fault_code, computed_sum and
// sentence_kind. The length limit is written through cfg_valid/cfg_ready with
// cfg_data; cfg_ready is always high.
// One byte is accepted per cycle. A carriage return produces a result that is
// valid in the cycle after its transaction; other bytes produce nothing, and
// the byte following a return is dropped.
// When the receiver stalls, the result is held in the output register; bytes
// that do not end a sentence, and the byte after a return, are still accepted.
// Only a carriage return waits for the output register to free up.
// Reset clears the sentence state, empties the output register and sets the
// length limit to 75.
// ----------------------------------------------------------------------------
module nmea_sentence_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       sentence_ok,
  output logic [2:0] fault_code,
  output logic [7:0] computed_sum,
  output logic [1:0] sentence_kind
);

  logic              take;
  logic              skip_next;
  logic              fire;
  logic              load;
  logic [7:0]        length_limit;
  nmea_pkg::result_t result;
  nmea_pkg::result_t result_reg;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready || skip_next || (rx_byte != nmea_pkg::CH_CR);
  assign take      = in_valid && in_ready;
  assign load      = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= nmea_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      length_limit <= cfg_data;
    end
  end

  nmea_tracker u_tracker (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .rx_byte      (rx_byte),
    .length_limit (length_limit),
    .skip_next    (skip_next),
    .fire         (fire),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_reg <= result;
    end
  end

  assign sentence_ok   = result_reg.ok;
  assign fault_code    = result_reg.fault;
  assign computed_sum  = result_reg.sum;
  assign sentence_kind = result_reg.kind;

  // a result is never loaded over one that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    load |-> (!out_valid || out_ready))
    else $error("result overwritten while stalled");

  // a return always arms the drop of the following byte
  assert property (@(posedge clk) disable iff (rst)
    load |=> skip_next)
    else $error("byte after return not dropped");

  // ok flag agrees with the fault code
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sentence_ok == (fault_code == nmea_pkg::FAULT_OK)))
    else $error("ok flag and fault code disagree");

  // the dropped byte never produces a result
  assert property (@(posedge clk) disable iff (rst)
    skip_next |-> !fire)
    else $error("result from dropped byte");

endmodule

@@ tb/sv/tb_nmea_sentence_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nmea_sentence_checker
// Streams NMEA-style byte sequences into the sentence checker and checks each
// per-sentence result against a cycle-free model of the checker. Covers
// directed corner sentences, several length limits, bursty input and random
// output back-pressure.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_checker;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam int QUIET_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {
    FEED_BYTE,
    FEED_CFG,
    FEED_PAUSE
  } feed_op_t;

  typedef struct packed {
    feed_op_t   op;
    logic [7:0] value;
  } feed_step_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       sentence_ok;
  logic [2:0] fault_code;
  logic [7:0] computed_sum;
  logic [1:0] sentence_kind;

  feed_step_t          feed_q[$];
  nmea_pkg::result_t   pending_results[$];
  int         bytes_fed = 0;
  logic [7:0] gen_sum;
  int         mismatches = 0;

  // driver pacing
  int burst_left = 0;
  int gap_left = 0;
  int quiet_count = 0;

  // receiver back-pressure
  int ready_left = 0;
  int stall_left = 0;

  int idle_cycles = 0;

  // checker model state
  logic [7:0]        limit_shadow;
  nmea_pkg::phase_t  sent_phase;
  logic [7:0]        sent_xor;
  logic [7:0]        sent_pos;
  logic [23:0]       kind_chars;
  logic [7:0]        hex_hi;
  logic [7:0]        hex_lo;
  logic              drop_next;
  nmea_pkg::fault_t  latched_fault;

  nmea_sentence_checker dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sentence_ok  (sentence_ok),
    .fault_code   (fault_code),
    .computed_sum (computed_sum),
    .sentence_kind(sentence_kind)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Sentence model
  // --------------------------------------------------------------------------
  function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'h30 + nib : 8'h41 + nib - 8'd10;
  endfunction

  task automatic clear_sentence();
    sent_phase    = nmea_pkg::PH_FIRST;
    sent_xor      = 8'h00;
    sent_pos      = 8'h00;
    kind_chars    = 24'h0;
    hex_hi        = 8'h00;
    hex_lo        = 8'h00;
    latched_fault = nmea_pkg::FAULT_OK;
  endtask

  function automatic nmea_pkg::fault_t closing_fault();
    nmea_pkg::fault_t f;
    case (sent_phase)
      nmea_pkg::PH_FIRST: f = nmea_pkg::FAULT_NO_DOLLAR;
      nmea_pkg::PH_SUM: begin
        // the return itself occupies one position
        f = ({1'b0, sent_pos} + 9'd1 >= {1'b0, limit_shadow}) ?
            nmea_pkg::FAULT_LENGTH : nmea_pkg::FAULT_NO_STAR;
      end
      nmea_pkg::PH_FAULT: f = latched_fault;
      default: begin
        f = (hex_hi == ascii_hex(sent_xor[7:4]) && hex_lo == ascii_hex(sent_xor[3:0])) ?
            nmea_pkg::FAULT_OK : nmea_pkg::FAULT_CHECKSUM;
      end
    endcase
    return f;
  endfunction

  task automatic take_char(input logic [7:0] c);
    nmea_pkg::result_t r;
    if (drop_next) begin
      drop_next = 1'b0;
    end else if (c == nmea_pkg::CH_CR) begin
      r.fault = closing_fault();
      r.ok    = (r.fault == nmea_pkg::FAULT_OK);
      r.sum   = (sent_phase == nmea_pkg::PH_FIRST) ? 8'h00 : sent_xor;
      if (kind_chars == nmea_pkg::CHARS_GGA) r.kind = nmea_pkg::KIND_GGA;
      else if (kind_chars == nmea_pkg::CHARS_GLL) r.kind = nmea_pkg::KIND_GLL;
      else if (kind_chars == nmea_pkg::CHARS_VTG) r.kind = nmea_pkg::KIND_VTG;
      else r.kind = nmea_pkg::KIND_OTHER;
      pending_results.push_back(r);
      clear_sentence();
      drop_next = 1'b1;
    end else begin
      case (sent_pos)
        nmea_pkg::KIND_POS_FIRST:  kind_chars[23:16] = c;
        nmea_pkg::KIND_POS_SECOND: kind_chars[15:8]  = c;
        nmea_pkg::KIND_POS_THIRD:  kind_chars[7:0]   = c;
        default: ;
      endcase
      case (sent_phase)
        nmea_pkg::PH_FIRST: begin
          if (c == nmea_pkg::CH_DOLLAR) begin
            sent_phase = nmea_pkg::PH_SUM;
          end else begin
            latched_fault = nmea_pkg::FAULT_NO_DOLLAR;
            sent_phase    = nmea_pkg::PH_FAULT;
          end
        end
        nmea_pkg::PH_SUM: begin
          if (sent_pos >= limit_shadow || c == nmea_pkg::CH_NUL) begin
            latched_fault = nmea_pkg::FAULT_LENGTH;
            sent_phase    = nmea_pkg::PH_FAULT;
          end else if (c == nmea_pkg::CH_STAR) begin
            sent_phase = nmea_pkg::PH_HEX1;
          end else begin
            sent_xor = sent_xor ^ c;
          end
        end
        nmea_pkg::PH_HEX1: begin
          hex_hi     = c;
          sent_phase = nmea_pkg::PH_HEX2;
        end
        nmea_pkg::PH_HEX2: begin
          hex_lo     = c;
          sent_phase = nmea_pkg::PH_DONE;
        end
        default: ;
      endcase
      if (sent_pos != 8'hFF) sent_pos = sent_pos + 8'd1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------
  task automatic feed_byte(input logic [7:0] b);
    feed_q.push_back('{op: FEED_BYTE, value: b});
    bytes_fed++;
  endtask

  task automatic feed_cfg(input logic [7:0] v);
    feed_q.push_back('{op: FEED_CFG, value: v});
  endtask

  task automatic feed_pause();
    feed_q.push_back('{op: FEED_PAUSE, value: 8'h00});
  endtask

  task automatic feed_text(input string s);
    for (int i = 0; i < s.len(); i++) feed_byte(s[i]);
  endtask

  task automatic feed_line(input string s);
    feed_text(s);
    feed_byte(nmea_pkg::CH_CR);
    feed_byte(CH_LF);
  endtask

  task automatic feed_summed(input logic [7:0] c);
    feed_byte(c);
    gen_sum = gen_sum ^ c;
  endtask

  task automatic feed_checked(input string body);
    gen_sum = 8'h00;
    feed_byte(nmea_pkg::CH_DOLLAR);
    for (int i = 0; i < body.len(); i++) feed_summed(body[i]);
    feed_byte(nmea_pkg::CH_STAR);
    feed_byte(ascii_hex(gen_sum[7:4]));
    feed_byte(ascii_hex(gen_sum[3:0]));
    feed_byte(nmea_pkg::CH_CR);
    feed_byte(CH_LF);
  endtask

  task automatic feed_random_sentence();
    int shape;
    int n;
    int tail;
    logic [7:0] c;
    logic [23:0] hdr;
    shape = $urandom_range(0, 99);
    if (shape < 3) feed_pause();
    if (shape >= 90) begin
      // raw noise, any byte value
      n = $urandom_range(0, 12);
      repeat (n) begin
        c = 8'($urandom_range(0, 255));
        feed_byte(c);
      end
      feed_byte(nmea_pkg::CH_CR);
      c = 8'($urandom_range(0, 255));
      feed_byte(c);
    end else begin
      gen_sum = 8'h00;
      feed_byte(nmea_pkg::CH_DOLLAR);
      repeat (2) begin
        c = ($urandom_range(0, 1) == 0) ? 8'h47 : 8'($urandom_range(8'h41, 8'h5A));
        feed_summed(c);
      end
      case ($urandom_range(0, 3))
        0: hdr = nmea_pkg::CHARS_GGA;
        1: hdr = nmea_pkg::CHARS_GLL;
        2: hdr = nmea_pkg::CHARS_VTG;
        default: hdr = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                        8'($urandom_range(65, 90))};
      endcase
      feed_summed(hdr[23:16]);
      feed_summed(hdr[15:8]);
      feed_summed(hdr[7:0]);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 10);
      repeat (n) begin
        if ($urandom_range(0, 39) == 0) begin
          c = 8'($urandom_range(0, 255));
          if (c == nmea_pkg::CH_CR) c = 8'h2C;
        end else begin
          c = 8'($urandom_range(32, 126));
          if (c == nmea_pkg::CH_STAR) c = 8'h2C;
        end
        feed_summed(c);
      end
      if ($urandom_range(0, 19) != 0) begin
        feed_byte(nmea_pkg::CH_STAR);
        tail = $urandom_range(0, 19);
        case (tail)
          0: begin
            feed_byte(ascii_hex(gen_sum[7:4] ^ 4'h1));
            feed_byte(ascii_hex(gen_sum[3:0]));
          end
          1: begin
            feed_byte(ascii_hex(gen_sum[7:4]) | 8'h20);
            feed_byte(ascii_hex(gen_sum[3:0]) | 8'h20);
          end
          2: feed_byte(ascii_hex(gen_sum[7:4]));
          3: ;
          default: begin
            feed_byte(ascii_hex(gen_sum[7:4]));
            feed_byte(ascii_hex(gen_sum[3:0]));
            if (tail == 4) begin
              repeat ($urandom_range(1, 5)) begin
                c = 8'($urandom_range(32, 126));
                feed_byte(c);
              end
            end
          end
        endcase
      end
      feed_byte(nmea_pkg::CH_CR);
      if ($urandom_range(0, 6) == 0) begin
        c = 8'($urandom_range(0, 255));
        feed_byte(c);
      end else begin
        feed_byte(CH_LF);
      end
    end
  endtask

  task automatic feed_random_until(input int total);
    while (bytes_fed < total) feed_random_sentence();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    // directed corners, reset limit
    feed_checked("GPGGA");
    feed_checked("GNGLL,5");
    feed_line("$GPVTG*00");
    feed_line("");
    feed_byte(8'hFF);
    feed_line("");
    feed_byte(nmea_pkg::CH_DOLLAR);
    feed_byte("G");
    feed_byte(nmea_pkg::CH_NUL);
    feed_line("");
    feed_line("$GP");
    feed_line("$GP*4");
    feed_line("$J*4a");
    feed_line("$J*4AXY");
    // byte after the return is not a line feed
    feed_text("$J*4A");
    feed_byte(nmea_pkg::CH_CR);
    feed_byte(nmea_pkg::CH_DOLLAR);

    feed_random_until(300);

    feed_pause();
    feed_cfg(8'd2);
    feed_random_until(380);

    feed_pause();
    feed_cfg(8'd255);
    // runs past the position counter range
    feed_byte(nmea_pkg::CH_DOLLAR);
    repeat (270) feed_byte("A");
    feed_byte(nmea_pkg::CH_CR);
    feed_byte(CH_LF);
    feed_random_until(680);

    feed_pause();
    feed_cfg(8'($urandom_range(6, 30)));
    feed_random_until(740);

    feed_pause();
    feed_cfg(nmea_pkg::LIMIT_RESET);
    feed_random_until(800);
    feed_pause();

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (feed_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of bytes, config writes and drain pauses
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      cfg_valid  <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
      quiet_count = 0;
    end else if ((in_valid && !in_ready) || (cfg_valid && !cfg_ready)) begin
      // hold current transaction
    end else if (gap_left != 0) begin
      gap_left--;
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else if (feed_q.size() == 0) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      case (feed_q[0].op)
        FEED_BYTE: begin
          in_valid  <= 1'b1;
          rx_byte   <= feed_q[0].value;
          cfg_valid <= 1'b0;
          void'(feed_q.pop_front());
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 :
                       ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
          end else begin
            burst_left--;
          end
        end
        FEED_CFG: begin
          in_valid  <= 1'b0;
          cfg_valid <= 1'b1;
          cfg_data  <= feed_q[0].value;
          void'(feed_q.pop_front());
        end
        default: begin
          in_valid  <= 1'b0;
          cfg_valid <= 1'b0;
          if (!in_valid && !cfg_valid && pending_results.size() == 0) quiet_count++;
          else quiet_count = 0;
          if (quiet_count >= QUIET_CYCLES) begin
            quiet_count = 0;
            void'(feed_q.pop_front());
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: result checking, model update and receiver stalls
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    nmea_pkg::result_t want;
    if (rst) begin
      out_ready    <= 1'b0;
      limit_shadow = nmea_pkg::LIMIT_RESET;
      drop_next    = 1'b0;
      clear_sentence();
      ready_left = 0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual ok=%0b fault=%0d sum=%0h kind=%0d",
                   $time, sentence_ok, fault_code, computed_sum, sentence_kind);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("sentence_ok", {7'd0, want.ok}, {7'd0, sentence_ok});
          check_field("fault_code", {5'd0, want.fault}, {5'd0, fault_code});
          check_field("computed_sum", want.sum, computed_sum);
          check_field("sentence_kind", {6'd0, want.kind}, {6'd0, sentence_kind});
        end
      end
      if (cfg_valid && cfg_ready) limit_shadow = cfg_data;
      if (in_valid && in_ready) take_char(rx_byte);

      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (ready_left != 0) begin
          ready_left--;
        end else begin
          ready_left = $urandom_range(0, 30);
          stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 3);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
